FILE: rtl/core/rbr_pkg.sv
// Shared types and constants for the receive byte ring.
// No dependencies.
`default_nettype none

package rbr_pkg;

    localparam int unsigned KIND_W = 2;
    localparam int unsigned DATA_W = 8;
    localparam int unsigned CNT_W  = 32;

    typedef enum logic [KIND_W-1:0] {
        KIND_RX       = 2'd0,
        KIND_LINE_ERR = 2'd1,
        KIND_READ     = 2'd2
    } kind_t;

    typedef logic [DATA_W-1:0] data_t;
    typedef logic [CNT_W-1:0]  cnt_t;

endpackage : rbr_pkg

`default_nettype wire

FILE: rtl/core/rbr_in_if.sv
// Input channel of the receive byte ring: valid/ready plus one item.
// Depends on rbr_pkg.
`default_nettype none

interface rbr_in_if;

    logic                        valid;
    logic                        ready;
    logic [rbr_pkg::KIND_W-1:0]  kind;
    rbr_pkg::data_t              rx_byte;

    modport source (output valid, output kind, output rx_byte, input ready);
    modport sink   (input valid, input kind, input rx_byte, output ready);

endinterface : rbr_in_if

`default_nettype wire

FILE: rtl/core/rbr_out_if.sv
// Result channel of the receive byte ring: valid/ready plus one item.
// Depends on rbr_pkg.
`default_nettype none

interface rbr_out_if;

    logic           valid;
    logic           ready;
    logic           read_valid;
    rbr_pkg::data_t read_data;
    rbr_pkg::cnt_t  overflow_count;
    rbr_pkg::cnt_t  total_count;

    modport source (output valid, output read_valid, output read_data,
                    output overflow_count, output total_count, input ready);
    modport sink   (input valid, input read_valid, input read_data,
                    input overflow_count, input total_count, output ready);

endinterface : rbr_out_if

`default_nettype wire

FILE: rtl/core/rx_byte_ring_drop_oldest.sv
// Top level of the receive byte ring that drops its oldest byte when full.
// Depends on rbr_pkg, rbr_in_if, rbr_out_if and rbr_ring_mem.
`default_nettype none

// The ring holds up to RING_DEPTH - 1 bytes (RING_DEPTH a power of two).
// Every item yields exactly one result with the overflow and received
// counters as they stand after the item. The ring memory is accessed in the
// accept cycle, and its registered read data is turned into the result in the
// next cycle, when the result register is loaded. The next item is accepted
// once that result has moved out or is being taken, so no new item is taken
// while one is still in flight.
// No clearing pass follows reset; reads only reach bytes already written.
module rx_byte_ring_drop_oldest #(
    parameter int unsigned RING_DEPTH = 128
) (
    input wire logic  clk,
    input wire logic  rst_n,
    rbr_in_if.sink    req,
    rbr_out_if.source rsp
);

    localparam int unsigned IDX_W = $clog2(RING_DEPTH);

    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    rbr_pkg::cnt_t    drop_reg, drop_next;
    rbr_pkg::cnt_t    total_reg, total_next;

    logic pend_reg;
    logic pend_hit_reg;

    logic           out_valid_reg;
    logic           out_rvalid_reg;
    rbr_pkg::data_t out_data_reg;
    rbr_pkg::cnt_t  out_drop_reg;
    rbr_pkg::cnt_t  out_total_reg;

    logic           accept;
    logic           is_rx;
    logic           is_rd;
    logic           full;
    logic           empty;
    logic           mem_wr;
    logic           mem_rd;
    rbr_pkg::data_t mem_rdata;

    assign req.ready = !pend_reg && (!out_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        is_rx = 1'b0;
        is_rd = 1'b0;
        unique case (req.kind)
            rbr_pkg::KIND_RX:       is_rx = 1'b1;
            rbr_pkg::KIND_READ:     is_rd = 1'b1;
            rbr_pkg::KIND_LINE_ERR: is_rx = 1'b0;
            default:                is_rx = 1'b0;
        endcase
    end

    assign empty  = (head_reg == tail_reg);
    assign full   = ((head_reg + IDX_W'(1)) == tail_reg);
    assign mem_wr = accept && is_rx;
    assign mem_rd = accept && is_rd && !empty;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        drop_next  = drop_reg;
        total_next = total_reg;
        if (mem_wr)
        begin
            head_next  = head_reg + IDX_W'(1);
            total_next = total_reg + rbr_pkg::CNT_W'(1);
            if (full)
            begin
                tail_next = tail_reg + IDX_W'(1);
                drop_next = drop_reg + rbr_pkg::CNT_W'(1);
            end
        end
        else if (mem_rd)
        begin
            tail_next = tail_reg + IDX_W'(1);
        end
    end

    rbr_ring_mem #(
        .DEPTH (RING_DEPTH)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr),
        .wr_addr (head_reg),
        .wr_data (req.rx_byte),
        .rd_en   (mem_rd),
        .rd_addr (tail_reg),
        .rd_data (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            drop_reg      <= '0;
            total_reg     <= '0;
            pend_reg      <= 1'b0;
            pend_hit_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            drop_reg  <= drop_next;
            total_reg <= total_next;
            pend_reg  <= accept;
            if (accept)
            begin
                pend_hit_reg <= mem_rd;
            end
            if (pend_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_reg)
        begin
            out_rvalid_reg <= pend_hit_reg;
            out_data_reg   <= pend_hit_reg ? mem_rdata : '0;
            out_drop_reg   <= drop_reg;
            out_total_reg  <= total_reg;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.read_valid     = out_rvalid_reg;
    assign rsp.read_data      = out_data_reg;
    assign rsp.overflow_count = out_drop_reg;
    assign rsp.total_count    = out_total_reg;

`ifndef ASSERT_OFF
    a_no_accept_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> !accept)
        else $error("item accepted while previous item in flight");

    a_pend_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |=> (out_valid_reg && !pend_reg))
        else $error("pending item did not reach result register");

    a_empty_read_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_rd && empty) |=> (!pend_hit_reg && (tail_reg == $past(tail_reg))))
        else $error("read of empty ring changed state");

    a_push_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_rx) |=> (head_reg != tail_reg))
        else $error("ring empty after push");
`endif

endmodule : rx_byte_ring_drop_oldest

`default_nettype wire

FILE: rtl/core/rbr_ring_mem.sv
// Byte store of the ring: one write port, one read port, registered read data.
// Depends on rbr_pkg.
`default_nettype none

module rbr_ring_mem #(
    parameter int unsigned DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire rbr_pkg::data_t           wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output      rbr_pkg::data_t           rd_data
);

    rbr_pkg::data_t mem [DEPTH];
    rbr_pkg::data_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule : rbr_ring_mem

`default_nettype wire

FILE: sim/tb_rx_byte_ring_drop_oldest.sv
// Testbench for rx_byte_ring_drop_oldest: directed and random items with random
// stalls, predicted by an in-bench ring model and checked field by field.
// Depends on rbr_pkg, rbr_in_if, rbr_out_if and the block's RTL.

module tb_rx_byte_ring_drop_oldest;

    import rbr_pkg::*;

    localparam int unsigned RING_DEPTH   = 128;
    localparam int unsigned IDX_W        = $clog2(RING_DEPTH);
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
    localparam int unsigned ITEM_GOAL    = 1600;
    localparam int unsigned MAX_GAP      = 17;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned DRAIN_CYCLES = 8;

    typedef struct packed {
        logic  read_valid;
        data_t read_data;
        cnt_t  overflow_count;
        cnt_t  total_count;
    } ring_result_t;

    typedef enum int unsigned {
        PHASE_FILL,
        PHASE_DRAIN,
        PHASE_MIXED
    } phase_t;

    class ring_scoreboard;
        data_t            slots [RING_DEPTH];
        logic [IDX_W-1:0] head;
        logic [IDX_W-1:0] tail;
        cnt_t             dropped;
        cnt_t             received;
        ring_result_t     due_results [$];
        int unsigned      errors;
        int unsigned      checked;
        int unsigned      empty_reads;
        int unsigned      peak_fill;

        function new();
            head        = '0;
            tail        = '0;
            dropped     = '0;
            received    = '0;
            errors      = 0;
            checked     = 0;
            empty_reads = 0;
            peak_fill   = 0;
            foreach (slots[i])
            begin
                slots[i] = '0;
            end
        endfunction

        function void note_item(logic [KIND_W-1:0] kind, data_t rx_byte);
            ring_result_t     res;
            logic [IDX_W-1:0] next;
            logic [IDX_W-1:0] fill;
            res = '0;
            if (kind == KIND_RX)
            begin
                next = head + 1'b1;
                if (next == tail)
                begin
                    tail    = tail + 1'b1;
                    dropped = dropped + 1'b1;
                end
                slots[head] = rx_byte;
                head        = next;
                received    = received + 1'b1;
            end
            else if (kind == KIND_READ)
            begin
                if (head != tail)
                begin
                    res.read_valid = 1'b1;
                    res.read_data  = slots[tail];
                    tail           = tail + 1'b1;
                end
                else
                begin
                    empty_reads++;
                end
            end
            res.overflow_count = dropped;
            res.total_count    = received;
            fill = head - tail;
            if (fill > peak_fill)
            begin
                peak_fill = fill;
            end
            due_results.push_back(res);
        endfunction

        function void check_result(logic rv, data_t rd, cnt_t ovf, cnt_t tot);
            ring_result_t exp_res;
            if (due_results.size() == 0)
            begin
                $error("result with no item outstanding");
                errors++;
                return;
            end
            exp_res = due_results.pop_front();
            checked++;
            if (rv !== exp_res.read_valid)
            begin
                $error("read_valid: expected %0d, got %0d", exp_res.read_valid, rv);
                errors++;
            end
            if (rd !== exp_res.read_data)
            begin
                $error("read_data: expected 0x%02h, got 0x%02h", exp_res.read_data, rd);
                errors++;
            end
            if (ovf !== exp_res.overflow_count)
            begin
                $error("overflow_count: expected %0d, got %0d", exp_res.overflow_count, ovf);
                errors++;
            end
            if (tot !== exp_res.total_count)
            begin
                $error("total_count: expected %0d, got %0d", exp_res.total_count, tot);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return due_results.size();
        endfunction
    endclass

    logic           clk;
    logic           rst_n;
    logic           calm_in;
    logic           calm_out;
    int unsigned    cycles = 0;
    ring_scoreboard sb;

    rbr_in_if  req ();
    rbr_out_if rsp ();

    rx_byte_ring_drop_oldest #(
        .RING_DEPTH (RING_DEPTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles", cycles);
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
        begin
            sb.check_result(rsp.read_valid, rsp.read_data, rsp.overflow_count,
                            rsp.total_count);
        end
        if (rst_n && req.valid && req.ready)
        begin
            sb.note_item(req.kind, req.rx_byte);
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_item(input logic [KIND_W-1:0] kind, input data_t rx_byte);
        int unsigned gap;
        gap = calm_in ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req.valid   <= 1'b1;
        req.kind    <= kind;
        req.rx_byte <= rx_byte;
        do @(posedge clk); while (!req.ready);
        @(negedge clk);
    endtask

    function automatic logic [KIND_W-1:0] pick_kind(phase_t phase);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 2)
        begin
            return KIND_LINE_ERR;
        end
        if (roll < 4)
        begin
            return KIND_SPARE;
        end
        case (phase)
            PHASE_FILL:  return (roll < 90) ? KIND_RX : KIND_READ;
            PHASE_DRAIN: return (roll < 14) ? KIND_RX : KIND_READ;
            default:     return (roll < 52) ? KIND_RX : KIND_READ;
        endcase
    endfunction

    task automatic run_directed();
        send_item(KIND_READ, 8'hFF);        // empty ring
        send_item(KIND_LINE_ERR, 8'hFF);
        send_item(KIND_SPARE, 8'h00);
        send_item(KIND_RX, 8'h00);
        send_item(KIND_RX, 8'hFF);
        send_item(KIND_RX, 8'h80);
        send_item(KIND_RX, 8'h01);
        send_item(KIND_LINE_ERR, 8'h3C);
        send_item(KIND_READ, 8'h00);
        send_item(KIND_SPARE, 8'hFF);
        send_item(KIND_READ, 8'h00);
        send_item(KIND_READ, 8'hFF);
        send_item(KIND_READ, 8'h00);
        send_item(KIND_READ, 8'h00);        // drained again
        send_item(KIND_RX, 8'h55);
        send_item(KIND_RX, 8'hAA);
        send_item(KIND_READ, 8'h00);
        send_item(KIND_LINE_ERR, 8'h00);
        send_item(KIND_READ, 8'h00);
        send_item(KIND_READ, 8'h00);
    endtask

    initial
    begin : result_taker
        int unsigned stall;
        @(posedge rst_n);
        forever
        begin
            stall = calm_out ? 0 : $urandom_range(0, MAX_GAP);
            if (stall != 0)
            begin
                rsp.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp.ready <= 1'b1;
            do @(posedge clk); while (!rsp.valid);
            @(negedge clk);
        end
    end

    initial
    begin : stimulus
        phase_t            phase;
        int unsigned       seg_len;
        int unsigned       counted;
        int unsigned       i;
        logic [KIND_W-1:0] kind;
        sb          = new();
        rst_n       = 1'b0;
        calm_in     = 1'b0;
        calm_out    = 1'b0;
        req.valid   = 1'b0;
        req.kind    = KIND_RX;
        req.rx_byte = '0;
        rsp.ready   = 1'b0;
        counted     = 0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        run_directed();

        // fill phases can run long enough to wrap the ring and force drops
        while (counted < ITEM_GOAL)
        begin
            phase    = phase_t'($urandom_range(0, 2));
            seg_len  = (phase == PHASE_FILL) ? $urandom_range(60, 260)
                                             : $urandom_range(10, 150);
            calm_in  = ($urandom_range(0, 4) == 0);
            calm_out = ($urandom_range(0, 4) == 0);
            for (i = 0; i < seg_len; i++)
            begin
                kind = pick_kind(phase);
                send_item(kind, data_t'($urandom_range(0, 255)));
                if (kind == KIND_RX || kind == KIND_READ)
                begin
                    counted++;
                end
            end
        end
        req.valid <= 1'b0;

        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
        begin
            $error("%0d expected results never arrived", sb.pending());
            sb.errors++;
        end

        $display("Checked %0d results: %0d bytes received, %0d dropped on a full ring,",
                 sb.checked, sb.received, sb.dropped);
        $display("%0d reads of an empty ring, fill peaked at %0d of %0d bytes.",
                 sb.empty_reads, sb.peak_fill, RING_DEPTH - 1);
        if (sb.errors == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule : tb_rx_byte_ring_drop_oldest

FILE: filelist.f
rtl/core/rbr_pkg.sv
rtl/core/rbr_in_if.sv
rtl/core/rbr_out_if.sv
rtl/core/rbr_ring_mem.sv
rtl/core/rx_byte_ring_drop_oldest.sv
sim/tb_rx_byte_ring_drop_oldest.sv
